// ===== hw/rtl/pfdd_pkg.sv =====
// Shared constants and helpers for the Playfair digraph decrypt core.
// Key square geometry, letter codes, register indexes and reset key.
// No dependencies.
`timescale 1ns / 1ps

package pfdd_pkg;

	localparam int LETTER_W    = 5;
	localparam int LETTERS     = 26;
	localparam int SQ_SIDE     = 5;
	localparam int SQ_CELLS    = 25;
	localparam int KEY_MAX_DEF = 12;
	localparam int KEY_W       = 60;
	localparam int KLEN_W      = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 60;
	localparam int TDATA_W     = 16;

	localparam logic [LETTER_W-1:0] LETTER_I = 5'd8;
	localparam logic [LETTER_W-1:0] LETTER_J = 5'd9;

	// "playfair", first letter in the low bits
	localparam logic [KEY_W-1:0]  RESET_KEY     = 60'd592711516527;
	localparam logic [KLEN_W-1:0] RESET_KEY_LEN = 4'd8;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_LETTERS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH  = 2'd1;

	// row of a square position 0..24
	function automatic logic [2:0] row_of(input logic [LETTER_W-1:0] p);
		logic [2:0] r;
		if (p >= 5'd20)      r = 3'd4;
		else if (p >= 5'd15) r = 3'd3;
		else if (p >= 5'd10) r = 3'd2;
		else if (p >= 5'd5)  r = 3'd1;
		else                 r = 3'd0;
		return r;
	endfunction

	function automatic logic [2:0] col_of(input logic [LETTER_W-1:0] p, input logic [2:0] r);
		logic [LETTER_W-1:0] base;
		logic [LETTER_W-1:0] diff;
		base = 5'({r, 2'b00}) + 5'(r);
		diff = p - base;
		return diff[2:0];
	endfunction

	function automatic logic [LETTER_W-1:0] pos_at(input logic [2:0] r, input logic [2:0] c);
		return 5'({r, 2'b00}) + 5'(r) + 5'(c);
	endfunction

	// one step back with wrap over 0..4
	function automatic logic [2:0] dec5(input logic [2:0] v);
		return (v == 3'd0) ? 3'(SQ_SIDE - 1) : v - 3'd1;
	endfunction

endpackage

// ===== hw/rtl/playfair_digraph_decrypt_core.sv =====
// Playfair digraph decrypt core: key square builder, lookup pipeline.
// Depends on pfdd_pkg.
`timescale 1ns / 1ps

// Usage
// - s_* channel: one ciphertext word per handshake (a letter pair, a=0..z=25).
// - m_* channel: one plaintext word per input word, in order.
// - cfg_*: write key_letters (index 0) or key_length (index 1) while idle.
//   Other indexes are ignored. Each accepted write rebuilds the key square.
// Path: the position table read is registered in stage 1, then the square
//   read goes into the output register.
// Throughput: one word per cycle unless stalled or rebuilding; each stage has its
//   own valid bit, so stage 1 can take a word while the output register holds one.
// Rebuild: after reset and after each config write the builder walks the first
//   min(key_length, KEY_MAX_LETTERS) key letters, then the alphabet, one candidate
//   per cycle. s_tready stays low meanwhile.
// A letter j is looked up as i; codes above 25 are treated as square position 0.
// Stall: when m_tready is low the output holds, stage 1 fills, and then
//   s_tready drops until the output word is taken.
module playfair_digraph_decrypt_core #(
	parameter int KEY_MAX_LETTERS = pfdd_pkg::KEY_MAX_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// config write port
	input  logic                             cfg_we,
	input  logic [pfdd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pfdd_pkg::CFG_DATA_W-1:0]  cfg_data,
	// input stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [pfdd_pkg::TDATA_W-1:0]     s_tdata,   // [4:0] cipher_first, [9:5] cipher_second
	// output stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [pfdd_pkg::TDATA_W-1:0]     m_tdata    // [4:0] plain_first, [9:5] plain_second
);

	localparam int LW  = pfdd_pkg::LETTER_W;
	localparam int KIW = (KEY_MAX_LETTERS > 1) ? $clog2(KEY_MAX_LETTERS) : 1;
	localparam logic [pfdd_pkg::KLEN_W-1:0] KMAX = pfdd_pkg::KLEN_W'(KEY_MAX_LETTERS);

	typedef enum logic [1:0] {B_KEY, B_ALPHA, B_IDLE} bld_state_t;

	// ---------------------------------------------------------------
	// Key registers and square builder
	// ---------------------------------------------------------------
	bld_state_t                   bld_state_q;
	logic [LW-1:0]                key_q [KEY_MAX_LETTERS];
	logic [pfdd_pkg::KLEN_W-1:0]  key_len_q;
	logic [pfdd_pkg::KLEN_W-1:0]  key_cnt_q;
	logic [LW-1:0]                alpha_q;
	logic [LW-1:0]                count_q;     // next free square cell
	logic [pfdd_pkg::LETTERS-1:0] placed_q;

	logic [pfdd_pkg::KLEN_W-1:0]  n_eff;
	logic                         key_active;
	logic [LW-1:0]                cand;
	logic                         cand_seen;
	logic                         take;
	logic                         cfg_hit;

	assign n_eff      = (key_len_q > KMAX) ? KMAX : key_len_q;
	assign key_active = (bld_state_q == B_KEY) && (key_cnt_q < n_eff);
	assign cand       = key_active ? key_q[key_cnt_q[KIW-1:0]] : alpha_q;
	assign cand_seen  = (cand < LW'(pfdd_pkg::LETTERS)) ? placed_q[cand] : 1'b1;
	assign take       = (key_active || (bld_state_q == B_ALPHA))
	                    && (cand != pfdd_pkg::LETTER_J) && !cand_seen
	                    && (count_q < LW'(pfdd_pkg::SQ_CELLS));
	assign cfg_hit    = cfg_we && ((cfg_index == pfdd_pkg::REG_KEY_LETTERS)
	                    || (cfg_index == pfdd_pkg::REG_KEY_LENGTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bld_state_q <= B_KEY;
			for (int k = 0; k < KEY_MAX_LETTERS; k++) begin
				key_q[k] <= pfdd_pkg::RESET_KEY[5*k +: 5];
			end
			key_len_q <= pfdd_pkg::RESET_KEY_LEN;
			key_cnt_q <= '0;
			alpha_q   <= '0;
			count_q   <= '0;
			placed_q  <= '0;
		end else if (cfg_hit) begin
			// restart the build from the new key
			if (cfg_index == pfdd_pkg::REG_KEY_LETTERS) begin
				for (int k = 0; k < KEY_MAX_LETTERS; k++) begin
					key_q[k] <= cfg_data[5*k +: 5];
				end
			end else begin
				key_len_q <= cfg_data[pfdd_pkg::KLEN_W-1:0];
			end
			bld_state_q <= B_KEY;
			key_cnt_q   <= '0;
			alpha_q     <= '0;
			count_q     <= '0;
			placed_q    <= '0;
		end else begin
			if (take) begin
				placed_q[cand] <= 1'b1;
				count_q        <= count_q + 1'b1;
			end
			case (bld_state_q)
				B_KEY: begin
					if (key_active) key_cnt_q <= key_cnt_q + 1'b1;
					else            bld_state_q <= B_ALPHA;
				end
				B_ALPHA: begin
					if (alpha_q == LW'(pfdd_pkg::LETTERS - 1)) bld_state_q <= B_IDLE;
					else                                       alpha_q <= alpha_q + 1'b1;
				end
				B_IDLE: begin
				end
				default: bld_state_q <= B_IDLE;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Pipeline control: stage 1 (position read), output (square read)
	// ---------------------------------------------------------------
	logic valid_s1;
	logic out_valid_q;
	logic adv_out;
	logic adv_s1;
	logic s_accept;

	assign adv_out  = !out_valid_q || m_tready;
	assign adv_s1   = !valid_s1 || adv_out;
	assign s_tready = adv_s1 && (bld_state_q == B_IDLE);
	assign s_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1)  valid_s1    <= s_accept;
			if (adv_out) out_valid_q <= valid_s1;
		end
	end

	// ---------------------------------------------------------------
	// Letter -> position table
	// ---------------------------------------------------------------
	logic [LW-1:0] pos_mem [pfdd_pkg::LETTERS];
	logic [LW-1:0] cin1, cin2;
	logic          bad1, bad2;
	logic [LW-1:0] addr1, addr2;
	logic [LW-1:0] pos1_s1, pos2_s1;
	logic          bad1_s1, bad2_s1;

	assign cin1  = s_tdata[LW-1:0];
	assign cin2  = s_tdata[2*LW-1:LW];
	assign bad1  = (cin1 >= LW'(pfdd_pkg::LETTERS));
	assign bad2  = (cin2 >= LW'(pfdd_pkg::LETTERS));
	// j reads as i; out-of-range codes are forced to position 0 downstream
	assign addr1 = bad1 ? '0 : ((cin1 == pfdd_pkg::LETTER_J) ? pfdd_pkg::LETTER_I : cin1);
	assign addr2 = bad2 ? '0 : ((cin2 == pfdd_pkg::LETTER_J) ? pfdd_pkg::LETTER_I : cin2);

	always_ff @(posedge clk) begin
		if (take) pos_mem[cand] <= count_q;
		if (s_accept) begin
			pos1_s1 <= pos_mem[addr1];
			pos2_s1 <= pos_mem[addr2];
			bad1_s1 <= bad1;
			bad2_s1 <= bad2;
		end
	end

	// ---------------------------------------------------------------
	// Digraph rules
	// ---------------------------------------------------------------
	logic [LW-1:0] p1, p2, q1, q2;
	logic [2:0]    r1, c1, r2, c2;

	always_comb begin
		p1 = bad1_s1 ? '0 : pos1_s1;
		p2 = bad2_s1 ? '0 : pos2_s1;
		r1 = pfdd_pkg::row_of(p1);
		r2 = pfdd_pkg::row_of(p2);
		c1 = pfdd_pkg::col_of(p1, r1);
		c2 = pfdd_pkg::col_of(p2, r2);
		if (r1 == r2) begin
			// same row (also a doubled letter): shift left
			q1 = pfdd_pkg::pos_at(r1, pfdd_pkg::dec5(c1));
			q2 = pfdd_pkg::pos_at(r2, pfdd_pkg::dec5(c2));
		end else if (c1 == c2) begin
			// same column: shift up
			q1 = pfdd_pkg::pos_at(pfdd_pkg::dec5(r1), c1);
			q2 = pfdd_pkg::pos_at(pfdd_pkg::dec5(r2), c2);
		end else begin
			// rectangle: swap columns
			q1 = pfdd_pkg::pos_at(r1, c2);
			q2 = pfdd_pkg::pos_at(r2, c1);
		end
	end

	// ---------------------------------------------------------------
	// Key square, read straight into the output register
	// ---------------------------------------------------------------
	logic [LW-1:0] sq_mem [pfdd_pkg::SQ_CELLS];
	logic [LW-1:0] plain_first_q, plain_second_q;

	always_ff @(posedge clk) begin
		if (take) sq_mem[count_q] <= cand;
		if (adv_out && valid_s1) begin
			plain_first_q  <= sq_mem[q1];
			plain_second_q <= sq_mem[q2];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(pfdd_pkg::TDATA_W - 2*LW)'(0), plain_second_q, plain_first_q};

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_build_complete: assert property (@(posedge clk) disable iff (!arst_n)
		(bld_state_q == B_IDLE) |->
		(count_q == LW'(pfdd_pkg::SQ_CELLS)) && ($countones(placed_q) == pfdd_pkg::SQ_CELLS))
		else $error("square build finished without 25 placed letters");

	a_no_j_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[LW-1:0] != pfdd_pkg::LETTER_J)
		&& (m_tdata[2*LW-1:LW] != pfdd_pkg::LETTER_J))
		else $error("decoded letter j cannot come from the square");

	a_no_accept_building: assert property (@(posedge clk) disable iff (!arst_n)
		(bld_state_q != B_IDLE) |=> !valid_s1 || $past(valid_s1 && !adv_out))
		else $error("word entered the pipeline during a square rebuild");

	a_placed_count: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> ($countones(placed_q) == 32'(count_q)) || $past(cfg_hit))
		else $error("placed letters and fill count disagree");

endmodule
